// File: rtl/cig_pkg.sv
// shared types and constants of the cigar coverage sweep
package cig_pkg;

    localparam int POS_W       = 31;
    localparam int CHAR_W      = 8;
    localparam int DEPTH_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int NRES_W      = 7;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [NRES_W-1:0] MAX_RESULTS = 7'd64;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNSORTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NEG      = 2'd3;

    localparam logic [CHAR_W-1:0] CH_0  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_M  = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_I  = 8'h49;
    localparam logic [CHAR_W-1:0] CH_D  = 8'h44;
    localparam logic [CHAR_W-1:0] CH_N  = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_S  = 8'h53;
    localparam logic [CHAR_W-1:0] CH_H  = 8'h48;
    localparam logic [CHAR_W-1:0] CH_P  = 8'h50;
    localparam logic [CHAR_W-1:0] CH_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_EQ = 8'h3D;

    typedef struct packed {
        logic ins;
        logic pop;
        logic clr;
    } store_ctl_t;

    typedef struct packed {
        logic [POS_W-1:0]    seg_start;
        logic [POS_W-1:0]    seg_finish;
        logic [DEPTH_W-1:0]  depth;
        logic [STATUS_W-1:0] status;
        logic                run_last;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD,
        S_FCNT,
        S_TOP,
        S_END,
        S_BEG,
        S_EVAL,
        S_SWDONE,
        S_PARSE,
        S_APPLY,
        S_LAST,
        S_FIN
    } state_t;

endpackage

// File: rtl/cig_if.sv
// stream and configuration channel interfaces
interface cig_in_if;
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic [30:0]              read_start;
    logic [7:0]               cigar_char;
    logic                     read_last;
    modport source (output valid, mode, read_start, cigar_char, read_last, input ready);
    modport sink (input valid, mode, read_start, cigar_char, read_last, output ready);
endinterface

interface cig_out_if;
    logic                     valid;
    logic                     ready;
    logic [30:0]              seg_start;
    logic [30:0]              seg_finish;
    logic [15:0]              depth;
    logic [1:0]               status;
    logic                     run_last;
    modport source (output valid, seg_start, seg_finish, depth, status, run_last,
                    input ready);
    modport sink (input valid, seg_start, seg_finish, depth, status, run_last,
                  output ready);
endinterface

interface cig_cfg_if;
    logic                     valid;
    logic                     ready;
    logic                     count_reads_only;
    modport source (output valid, count_reads_only, input ready);
    modport sink (input valid, count_reads_only, output ready);
endinterface

// File: rtl/cig_cell.sv
// one entry of a sorted event store: key, count, valid
module cig_cell
    import cig_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  store_ctl_t            ctl,
    input  logic [POS_W-1:0]      ins_key,
    input  logic                  hit,
    input  logic                  left_valid,
    input  logic                  left_lt,
    input  logic [POS_W-1:0]      left_key,
    input  logic [COUNT_BITS-1:0] left_count,
    input  logic                  right_valid,
    input  logic [POS_W-1:0]      right_key,
    input  logic [COUNT_BITS-1:0] right_count,
    output logic                  valid,
    output logic [POS_W-1:0]      key,
    output logic [COUNT_BITS-1:0] count,
    output logic                  lt,
    output logic                  eq
);

    logic                  valid_reg, valid_next;
    logic [POS_W-1:0]      key_reg, key_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  place_new;
    logic                  shift_in;

    assign lt        = valid_reg && (key_reg < ins_key);
    assign eq        = valid_reg && (key_reg == ins_key);
    assign place_new = left_valid && left_lt;
    assign shift_in  = left_valid && !left_lt;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        count_next = count_reg;
        if (ctl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.pop)
        begin
            valid_next = right_valid;
            key_next   = right_key;
            count_next = right_count;
        end
        else if (ctl.ins)
        begin
            if (hit)
            begin
                if (eq && (count_reg != {COUNT_BITS{1'b1}}))
                begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
            end
            else if (place_new && !lt)
            begin
                valid_next = 1'b1;
                key_next   = ins_key;
                count_next = COUNT_BITS'(1);
            end
            else if (shift_in)
            begin
                valid_next = 1'b1;
                key_next   = left_key;
                count_next = left_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign count = count_reg;

endmodule

// File: rtl/cig_store.sv
// sorted event store built as a row of cells, head at cell zero
module cig_store
    import cig_pkg::*;
#(
    parameter int DEPTH      = 32,
    parameter int COUNT_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  store_ctl_t            ctl,
    input  logic [POS_W-1:0]      ins_key,
    output logic                  head_valid,
    output logic [POS_W-1:0]      head_key,
    output logic [COUNT_BITS-1:0] head_count,
    output logic                  room
);

    logic [DEPTH-1:0]      valid;
    logic [DEPTH-1:0]      lt;
    logic [DEPTH-1:0]      eq;
    logic [POS_W-1:0]      key   [DEPTH];
    logic [COUNT_BITS-1:0] count [DEPTH];
    logic                  hit;

    assign hit = |eq;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                  lv, llt, rv;
            logic [POS_W-1:0]      lk, rk;
            logic [COUNT_BITS-1:0] lc, rc;
            if (i == 0)
            begin : g_first
                // the head sees an always-smaller neighbor on its left
                assign lv  = 1'b1;
                assign llt = 1'b1;
                assign lk  = '0;
                assign lc  = '0;
            end
            else
            begin : g_mid
                assign lv  = valid[i-1];
                assign llt = lt[i-1];
                assign lk  = key[i-1];
                assign lc  = count[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_tail
                assign rv = 1'b0;
                assign rk = '0;
                assign rc = '0;
            end
            else
            begin : g_body
                assign rv = valid[i+1];
                assign rk = key[i+1];
                assign rc = count[i+1];
            end
            cig_cell #(
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .ins_key     (ins_key),
                .hit         (hit),
                .left_valid  (lv),
                .left_lt     (llt),
                .left_key    (lk),
                .left_count  (lc),
                .right_valid (rv),
                .right_key   (rk),
                .right_count (rc),
                .valid       (valid[i]),
                .key         (key[i]),
                .count       (count[i]),
                .lt          (lt[i]),
                .eq          (eq[i])
            );
        end
    endgenerate

    assign head_valid = valid[0];
    assign head_key   = key[0];
    assign head_count = count[0];
    assign room       = hit || !valid[DEPTH-1];

endmodule

// File: rtl/cigar_coverage_sweep.sv
// top level: cigar parser, coverage sweep sequencer and result staging
//
//  channel  dir  handshake      beat carries
//  item     in   valid/ready    mode, read_start, cigar_char, read_last
//  result   out  valid/ready    seg_start, seg_finish, depth, status, run_last
//  cfg      in   valid/ready    count_reads_only
//
// one item at a time: with no sweep work an m, x, =, d or n passes head, sweep
// check, sweep done, parse, apply, last, finish and idle; other characters skip
// apply, count mode skips parse as well, a dropped read passes head, last and finish,
// an empty flush passes flush count, sweep check, sweep done and finish. each sweep
// step: check, end pops, start pops, evaluate; a flush sweeps every stored event.
// reset empties both stores at once through the cell valid bits.
// a stalled result port holds the sequencer once two results are waiting.
module cigar_coverage_sweep
    import cig_pkg::*;
#(
    parameter int EVENT_DEPTH = 32,
    parameter int COUNT_BITS  = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    cig_in_if.sink     item,
    cig_out_if.source  result,
    cig_cfg_if.sink    cfg
);

    localparam int DW = (COUNT_BITS > DEPTH_W) ? COUNT_BITS : DEPTH_W;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    state_t state_reg, state_next;

    logic                  cro_reg;
    logic                  mode_reg;
    logic [POS_W-1:0]      rstart_reg;
    logic [CHAR_W-1:0]     ch_reg;
    logic                  last_reg;

    logic [COUNT_BITS-1:0] depth_reg, depth_next;
    logic [POS_W-1:0]      bound_reg, bound_next;
    logic [POS_W-1:0]      la_reg, la_next;
    logic [POS_W-1:0]      walk_reg, walk_next;
    logic [POS_W-1:0]      prev_reg, prev_next;
    logic [COUNT_BITS-1:0] ssc_reg, ssc_next;
    logic                  in_read_reg, in_read_next;
    logic                  drop_reg, drop_next;
    logic [NRES_W-1:0]     n_reg, n_next;
    logic                  neg_reg, neg_next;
    logic [POS_W-1:0]      s_reg, s_next;
    logic [POS_W-1:0]      stop_reg, stop_next;

    res_t                  out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  pend_reg, pend_next;
    logic                  pend_valid_reg, pend_valid_next;

    store_ctl_t            sctl, ectl;
    logic                  s_hv, e_hv, s_room, e_room;
    logic [POS_W-1:0]      s_hk, e_hk;
    logic [COUNT_BITS-1:0] s_hc, e_hc;

    logic                  emit_ok;
    logic                  bounded;
    logic [NRES_W-1:0]     cap;
    logic [POS_W-1:0]      s_cand, f_cand;
    logic                  top_done;
    logic                  end_pop, beg_pop;
    logic                  unsorted;
    logic                  cnt_emit;
    logic                  is_digit;
    logic                  is_walk_ev, is_skip, is_clip;
    logic                  f_stop;
    logic [POS_W-1:0]      prev_inc;
    logic [DW-1:0]         depth_ext, ssc_ext;
    logic [DEPTH_W-1:0]    depth_cap, ssc_cap;
    logic [COUNT_BITS:0]   dsum;
    logic [COUNT_BITS-1:0] dsat;
    logic [COUNT_BITS:0]   ssum;
    logic [COUNT_BITS-1:0] ssat;
    logic [34:0]           la_mul;
    logic [POS_W:0]        stop_sum;

    // ---------------- shared conditions ----------------
    assign emit_ok  = !pend_valid_reg || !out_valid_reg || result.ready;
    assign bounded  = !mode_reg;
    assign cap      = mode_reg ? MAX_RESULTS : (MAX_RESULTS - NRES_W'(1));
    assign s_cand   = (depth_reg != '0) ? bound_reg : s_hk;
    assign top_done = (n_reg >= cap) || ((depth_reg == '0) && !s_hv)
                      || (bounded && (s_cand >= prev_reg));
    assign end_pop  = e_hv && (e_hk <= s_reg);
    assign beg_pop  = s_hv && (s_hk <= s_reg);
    always_comb
    begin
        if (!s_hv)
        begin
            f_cand = e_hk;
        end
        else if (!e_hv)
        begin
            f_cand = s_hk;
        end
        else
        begin
            f_cand = (e_hk < s_hk) ? e_hk : s_hk;
        end
    end
    assign f_stop   = bounded && (f_cand >= prev_reg);
    assign unsorted = rstart_reg < prev_reg;
    assign cnt_emit = cro_reg && (ssc_reg != '0) && (rstart_reg != prev_reg);
    assign prev_inc = (prev_reg == POS_MAX) ? POS_MAX : (prev_reg + POS_W'(1));

    assign depth_ext = DW'(depth_reg);
    assign ssc_ext   = DW'(ssc_reg);
    assign depth_cap = (depth_ext > DW'({DEPTH_W{1'b1}})) ? {DEPTH_W{1'b1}}
                                                          : depth_ext[DEPTH_W-1:0];
    assign ssc_cap   = (ssc_ext > DW'({DEPTH_W{1'b1}})) ? {DEPTH_W{1'b1}}
                                                        : ssc_ext[DEPTH_W-1:0];

    assign dsum = {1'b0, depth_reg} + {1'b0, s_hc};
    assign dsat = dsum[COUNT_BITS] ? CMAX : dsum[COUNT_BITS-1:0];
    assign ssum = {1'b0, (cnt_emit ? {COUNT_BITS{1'b0}} : ssc_reg)} + (COUNT_BITS+1)'(1);
    assign ssat = ssum[COUNT_BITS] ? CMAX : ssum[COUNT_BITS-1:0];

    // length times ten plus digit, saturated at the position limit
    assign la_mul   = (35'(la_reg) << 3) + (35'(la_reg) << 1)
                      + 35'(ch_reg - CH_0);
    assign stop_sum = {1'b0, walk_reg} + {1'b0, la_reg};

    always_comb
    begin
        is_digit   = 1'b0;
        is_walk_ev = 1'b0;
        is_skip    = 1'b0;
        is_clip    = 1'b0;
        case (ch_reg) inside
            [CH_0:CH_9]:              is_digit   = 1'b1;
            CH_M, CH_X, CH_EQ, CH_D:  is_walk_ev = 1'b1;
            CH_N:                     is_skip    = 1'b1;
            CH_I, CH_S, CH_H, CH_P:   is_clip    = 1'b1;
            default:                  is_digit   = 1'b0;
        endcase
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = item.mode ? S_FCNT : S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (emit_ok)
                begin
                    if (in_read_reg)
                    begin
                        state_next = drop_reg ? S_LAST : S_TOP;
                    end
                    else
                    begin
                        state_next = unsorted ? S_LAST : S_TOP;
                    end
                end
            end
            S_FCNT:
            begin
                if (emit_ok)
                begin
                    state_next = S_TOP;
                end
            end
            S_TOP:    state_next = top_done ? S_SWDONE : S_END;
            S_END:    state_next = end_pop ? S_END : S_BEG;
            S_BEG:    state_next = beg_pop ? S_BEG : S_EVAL;
            S_EVAL:
            begin
                if (emit_ok)
                begin
                    if (!neg_reg && (depth_reg != '0) && (s_hv || e_hv) && f_stop)
                    begin
                        state_next = S_SWDONE;
                    end
                    else
                    begin
                        state_next = S_TOP;
                    end
                end
            end
            S_SWDONE:
            begin
                if (mode_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = cro_reg ? S_LAST : S_PARSE;
                end
            end
            S_PARSE:  state_next = (is_walk_ev || is_skip) ? S_APPLY : S_LAST;
            S_APPLY:
            begin
                if (emit_ok)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:   state_next = S_FIN;
            S_FIN:
            begin
                if (!pend_valid_reg || !out_valid_reg || result.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb
    begin
        logic emit_en;
        logic fin_push;
        res_t emit_res;

        emit_en         = 1'b0;
        fin_push        = 1'b0;
        emit_res        = '0;
        depth_next      = depth_reg;
        bound_next      = bound_reg;
        la_next         = la_reg;
        walk_next       = walk_reg;
        prev_next       = prev_reg;
        ssc_next        = ssc_reg;
        in_read_next    = in_read_reg;
        drop_next       = drop_reg;
        n_next          = n_reg;
        neg_next        = neg_reg;
        s_next          = s_reg;
        stop_next       = stop_reg;
        sctl            = '0;
        ectl            = '0;

        case (state_reg)
            S_IDLE:
            begin
                n_next = '0;
            end
            S_HEAD:
            begin
                if (emit_ok && !in_read_reg)
                begin
                    in_read_next = 1'b1;
                    la_next      = '0;
                    if (unsorted)
                    begin
                        drop_next           = 1'b1;
                        emit_en             = 1'b1;
                        emit_res.seg_start  = rstart_reg;
                        emit_res.seg_finish = rstart_reg;
                        emit_res.status     = ST_UNSORTED;
                    end
                    else
                    begin
                        drop_next = 1'b0;
                        if (cro_reg)
                        begin
                            if (cnt_emit)
                            begin
                                emit_en             = 1'b1;
                                emit_res.seg_start  = prev_reg;
                                emit_res.seg_finish = prev_inc;
                                emit_res.depth      = ssc_cap;
                                emit_res.status     = ST_OK;
                            end
                            ssc_next = ssat;
                        end
                        prev_next = rstart_reg;
                        walk_next = rstart_reg;
                    end
                end
            end
            S_FCNT:
            begin
                if (emit_ok && (ssc_reg != '0))
                begin
                    emit_en             = 1'b1;
                    emit_res.seg_start  = prev_reg;
                    emit_res.seg_finish = prev_inc;
                    emit_res.depth      = ssc_cap;
                    emit_res.status     = ST_OK;
                    ssc_next            = '0;
                end
            end
            S_TOP:
            begin
                s_next   = s_cand;
                neg_next = 1'b0;
            end
            S_END:
            begin
                if (end_pop)
                begin
                    ectl.pop = 1'b1;
                    if (e_hc > depth_reg)
                    begin
                        neg_next   = 1'b1;
                        depth_next = '0;
                    end
                    else
                    begin
                        depth_next = depth_reg - e_hc;
                    end
                end
            end
            S_BEG:
            begin
                if (beg_pop)
                begin
                    sctl.pop   = 1'b1;
                    depth_next = dsat;
                end
                else
                begin
                    bound_next = s_reg;
                end
            end
            S_EVAL:
            begin
                if (emit_ok)
                begin
                    if (neg_reg)
                    begin
                        emit_en             = 1'b1;
                        emit_res.seg_start  = s_reg;
                        emit_res.seg_finish = s_reg;
                        emit_res.status     = ST_NEG;
                    end
                    else if (depth_reg == '0)
                    begin
                        depth_next = '0;
                    end
                    else if (!s_hv && !e_hv)
                    begin
                        // orphan depth with nothing pending
                        depth_next = '0;
                    end
                    else if (!f_stop)
                    begin
                        emit_en             = 1'b1;
                        emit_res.seg_start  = s_reg;
                        emit_res.seg_finish = f_cand;
                        emit_res.depth      = depth_cap;
                        emit_res.status     = ST_OK;
                        bound_next          = f_cand;
                    end
                end
            end
            S_SWDONE:
            begin
                if (mode_reg)
                begin
                    if ((depth_reg == '0) && !s_hv)
                    begin
                        ectl.clr   = 1'b1;
                        bound_next = '0;
                        prev_next  = '0;
                    end
                    in_read_next = 1'b0;
                    drop_next    = 1'b0;
                    la_next      = '0;
                    walk_next    = '0;
                end
            end
            S_PARSE:
            begin
                if (is_digit)
                begin
                    la_next = (la_mul > 35'(POS_MAX)) ? POS_MAX : la_mul[POS_W-1:0];
                end
                else if (is_clip)
                begin
                    la_next = '0;
                end
                stop_next = stop_sum[POS_W] ? POS_MAX : stop_sum[POS_W-1:0];
            end
            S_APPLY:
            begin
                if (emit_ok)
                begin
                    if (is_walk_ev && (stop_reg > walk_reg))
                    begin
                        if (s_room && e_room)
                        begin
                            sctl.ins = 1'b1;
                            ectl.ins = 1'b1;
                        end
                        else
                        begin
                            emit_en             = 1'b1;
                            emit_res.seg_start  = walk_reg;
                            emit_res.seg_finish = stop_reg;
                            emit_res.status     = ST_FULL;
                        end
                    end
                    walk_next = stop_reg;
                    la_next   = '0;
                end
            end
            S_LAST:
            begin
                if (last_reg)
                begin
                    in_read_next = 1'b0;
                    drop_next    = 1'b0;
                    la_next      = '0;
                end
            end
            S_FIN:
            begin
                fin_push = pend_valid_reg && (!out_valid_reg || result.ready);
            end
            default:
            begin
                n_next = n_reg;
            end
        endcase

        if (emit_en)
        begin
            n_next = n_reg + NRES_W'(1);
        end

        // result staging: the newest result waits in pend until the next one
        // or the end of the item tells whether it is the last
        out_valid_next  = out_valid_reg && !result.ready;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (emit_en)
        begin
            if (pend_valid_reg)
            begin
                out_next          = pend_reg;
                out_next.run_last = 1'b0;
                out_valid_next    = 1'b1;
            end
            pend_next       = emit_res;
            pend_valid_next = 1'b1;
        end
        else if (fin_push)
        begin
            out_next          = pend_reg;
            out_next.run_last = 1'b1;
            out_valid_next    = 1'b1;
            pend_valid_next   = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cro_reg        <= 1'b0;
            depth_reg      <= '0;
            bound_reg      <= '0;
            la_reg         <= '0;
            walk_reg       <= '0;
            prev_reg       <= '0;
            ssc_reg        <= '0;
            in_read_reg    <= 1'b0;
            drop_reg       <= 1'b0;
            n_reg          <= '0;
            neg_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg.valid)
            begin
                cro_reg <= cfg.count_reads_only;
            end
            depth_reg      <= depth_next;
            bound_reg      <= bound_next;
            la_reg         <= la_next;
            walk_reg       <= walk_next;
            prev_reg       <= prev_next;
            ssc_reg        <= ssc_next;
            in_read_reg    <= in_read_next;
            drop_reg       <= drop_next;
            n_reg          <= n_next;
            neg_reg        <= neg_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            mode_reg   <= item.mode;
            rstart_reg <= item.read_start;
            ch_reg     <= item.cigar_char;
            last_reg   <= item.read_last;
        end
        s_reg    <= s_next;
        stop_reg <= stop_next;
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    // ---------------- event stores ----------------
    cig_store #(
        .DEPTH      (EVENT_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_start_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sctl),
        .ins_key    (walk_reg),
        .head_valid (s_hv),
        .head_key   (s_hk),
        .head_count (s_hc),
        .room       (s_room)
    );

    cig_store #(
        .DEPTH      (EVENT_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_end_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ectl),
        .ins_key    (stop_reg),
        .head_valid (e_hv),
        .head_key   (e_hk),
        .head_count (e_hc),
        .room       (e_room)
    );

    // ---------------- ports ----------------
    assign item.ready        = (state_reg == S_IDLE);
    assign cfg.ready         = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.seg_start  = out_reg.seg_start;
    assign result.seg_finish = out_reg.seg_finish;
    assign result.depth      = out_reg.depth;
    assign result.status     = out_reg.status;
    assign result.run_last   = out_reg.run_last;

endmodule
